// ===== hdl/safd_pkg.sv =====
// Shared constants for the stereo align fractional delay block.
`default_nettype none

package safd_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 19;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BALANCE      = 2'd0,
        CFG_DELAY_OFFSET = 2'd1,
        CFG_MODE         = 2'd2
    } t_cfg_index;

    // Register widths
    localparam int BALANCE_BITS = 17;
    localparam int OFFSET_BITS  = 19;
    localparam int MODE_BITS    = 3;

    // Mode codes
    localparam logic [MODE_BITS-1:0] MODE_INVERT_SHORT = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_LONG         = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_INVERT_LONG  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_BYPASS       = 3'd5;

    // Gain: unsigned, units of 2^-16, 0..65536
    localparam int GAIN_BITS  = 17;
    localparam int GAIN_SHIFT = 16;
    localparam int HALF_GAIN  = 32768;

    // Delay magnitude: whole samples and 1/256 fraction
    localparam int FRAC_BITS   = 8;
    localparam int NEAR_BITS   = 10;
    localparam int MAG_BITS    = NEAR_BITS + FRAC_BITS;
    localparam int SHORT_LIMIT = 30 * 256;
    localparam int LONG_LIMIT  = 700 * 256;

endpackage : safd_pkg

`default_nettype wire

// ===== hdl/safd_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module safd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire               i_clk,
    input  wire               i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]   i_wr_data,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_a,
    output logic [WIDTH-1:0]  o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // read returns old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data_a <= r_mem[i_rd_addr_a];
        r_rd_data_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule : safd_ram

`default_nettype wire

// ===== hdl/safd_gain.sv =====
// Balance gain for one channel: optional negate, multiply, round, saturate.
`default_nettype none

module safd_gain
    import safd_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire signed [SAMPLE_BITS-1:0] i_sample,
    input  wire                          i_negate,
    input  wire [GAIN_BITS-1:0]          i_gain,
    output logic signed [SAMPLE_BITS-1:0] o_scaled
);

    localparam int PW = SAMPLE_BITS + GAIN_BITS + 2;
    localparam int RW = PW - GAIN_SHIFT;
    localparam logic signed [PW-1:0] ROUND_BIAS = PW'(HALF_GAIN);
    localparam logic signed [RW-1:0] SAT_MAX = RW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(-(2 ** (SAMPLE_BITS - 1)));

    logic signed [SAMPLE_BITS:0] s_operand;
    logic signed [PW-1:0]        n_prod;
    logic signed [PW-1:0]        r_prod;
    logic signed [PW-1:0]        s_biased;
    logic signed [RW-1:0]        s_round;

    always_comb begin
        s_operand = {i_sample[SAMPLE_BITS-1], i_sample};
        if (i_negate) begin
            s_operand = -s_operand;
        end
        n_prod = s_operand * $signed({1'b0, i_gain});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // ties round toward +inf: add half, floor
    always_comb begin
        s_biased = r_prod + ROUND_BIAS;
        s_round  = s_biased[PW-1:GAIN_SHIFT];
        if (s_round > SAT_MAX) begin
            o_scaled = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (s_round < SAT_MIN) begin
            o_scaled = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_scaled = s_round[SAMPLE_BITS-1:0];
        end
    end

endmodule : safd_gain

`default_nettype wire

// ===== hdl/stereo_align_fractional_delay_mono.sv =====
// Top level of the stereo align fractional delay block with mono output.
`default_nettype none

// Stereo alignment delay with mono sum. Each input word carries one stereo
// frame; each output word carries one saturated mono sample. Left is scaled by
// 0.5 - balance and right by 0.5 + balance (left negated first in modes 2 and
// 4). A positive delay_offset delays left, a negative one delays right, in
// 1/256 sample steps, limited to 30 samples in modes 0-2 and 700 in modes 3-4;
// mode 5 and up turns the delay off, and modes 6-7 also force unity-half gains.
// The delayed channel goes through a RING_DEPTH entry ring in one synchronous
// RAM with two read ports, read at the whole delay and one past it, then
// linearly interpolated. After reset the ring is swept to zero, one entry
// per cycle, so no input word is taken until the sweep is done (config
// writes are taken throughout). After that the per-frame sequencer takes
// each word through accept and gain multiply, ring write plus tap reads,
// interpolate, and mix into the output register. A finished sample sits in
// the output register while the next frame is accepted; the mix step waits
// only if that register is still full. Config is written via index/data with
// o_cfg_ready always high; write it only while no frame is in flight.
module stereo_align_fractional_delay_mono
    import safd_pkg::*;
#(
    parameter int RING_DEPTH  = 2048,
    parameter int SAMPLE_BITS = 24
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // frame input
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire signed [SAMPLE_BITS-1:0]  i_left_sample,
    input  wire signed [SAMPLE_BITS-1:0]  i_right_sample,
    // mono output
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_mono_sample,
    // config writes
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]       i_cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int IW = SAMPLE_BITS + FRAC_BITS + 3;   // interpolation accumulator
    localparam int SW = SAMPLE_BITS + 3;               // pre-saturation width
    localparam logic [AW:0]   DEPTH_W    = (AW + 1)'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(RING_DEPTH - 1);
    localparam logic signed [IW-1:0] INTERP_BIAS = IW'(2 ** (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] SAT_MAX = SW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(-(2 ** (SAMPLE_BITS - 1)));
    localparam logic signed [GAIN_BITS:0]   BAL_MAX = (GAIN_BITS + 1)'(HALF_GAIN);
    localparam logic signed [GAIN_BITS:0]   BAL_MIN = (GAIN_BITS + 1)'(-HALF_GAIN);
    localparam logic signed [OFFSET_BITS-1:0] LIM_SHORT = OFFSET_BITS'(SHORT_LIMIT);
    localparam logic signed [OFFSET_BITS-1:0] LIM_LONG  = OFFSET_BITS'(LONG_LIMIT);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_ACCESS = 5'b00100,
        ST_READ   = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SW-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // config registers
    logic signed [BALANCE_BITS-1:0] r_balance;
    logic signed [OFFSET_BITS-1:0]  r_delay_offset;
    logic [MODE_BITS-1:0]           r_mode;

    // sequencer and ring pointers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       r_clr_addr;

    // per-frame datapath
    logic [NEAR_BITS-1:0] r_near;
    logic [FRAC_BITS-1:0] r_frac;
    logic                 r_del_l, r_del_r;
    logic signed [SAMPLE_BITS-1:0] r_l, r_r;
    logic signed [IW-1:0] r_interp;
    logic                 r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    // decoded config
    logic                 s_invert, s_long, s_no_delay, s_unity;
    logic signed [GAIN_BITS:0]     s_bal;
    logic [GAIN_BITS-1:0] s_gain_l, s_gain_r;
    logic signed [GAIN_BITS:0]     s_gain_l_w, s_gain_r_w;
    logic signed [OFFSET_BITS-1:0] s_lim, s_off, s_mag_w;
    logic [MAG_BITS-1:0]  s_mag;

    // ring access
    logic                 s_we;
    logic [AW-1:0]        s_wr_addr;
    logic signed [SAMPLE_BITS-1:0] s_wr_data;
    logic [AW:0]          s_sum_a, s_sum_b;
    logic [AW-1:0]        s_rd_addr_a, s_rd_addr_b;
    logic [SAMPLE_BITS-1:0] s_rd_data_a, s_rd_data_b;
    logic signed [SAMPLE_BITS-1:0] s_scaled_l, s_scaled_r;

    // interpolation and mix
    logic signed [SAMPLE_BITS-1:0] s_tap_in, s_tap_a, s_tap_b, s_tap;
    logic signed [SAMPLE_BITS:0]   s_diff;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0] s_slope;
    logic signed [IW-1:0] s_base, n_interp, s_interp_biased;
    logic signed [SAMPLE_BITS-1:0] s_fin_l, s_fin_r;
    logic signed [SAMPLE_BITS:0]   s_mix;
    logic                 s_accept, s_load_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign s_accept    = i_in_valid && o_in_ready;
    assign s_load_out  = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balance      <= '0;
            r_delay_offset <= '0;
            r_mode         <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BALANCE:      r_balance      <= i_cfg_data[BALANCE_BITS-1:0];
                CFG_DELAY_OFFSET: r_delay_offset <= i_cfg_data[OFFSET_BITS-1:0];
                CFG_MODE:         r_mode         <= i_cfg_data[MODE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s_invert   = r_mode inside {MODE_INVERT_SHORT, MODE_INVERT_LONG};
        s_long     = r_mode inside {MODE_LONG, MODE_INVERT_LONG};
        s_no_delay = (r_mode >= MODE_BYPASS);
        s_unity    = (r_mode > MODE_BYPASS);

        // balance clamp to +-0.5, then the two gains
        s_bal = {r_balance[BALANCE_BITS-1], r_balance};
        if (s_bal > BAL_MAX) begin
            s_bal = BAL_MAX;
        end else if (s_bal < BAL_MIN) begin
            s_bal = BAL_MIN;
        end
        s_gain_l_w = BAL_MAX - s_bal;
        s_gain_r_w = BAL_MAX + s_bal;
        if (s_unity) begin
            s_gain_l_w = BAL_MAX;
            s_gain_r_w = BAL_MAX;
        end
        s_gain_l = s_gain_l_w[GAIN_BITS-1:0];
        s_gain_r = s_gain_r_w[GAIN_BITS-1:0];

        // offset clamp by range, magnitude split into whole and fraction
        s_lim = s_long ? LIM_LONG : LIM_SHORT;
        s_off = r_delay_offset;
        if (s_off > s_lim) begin
            s_off = s_lim;
        end else if (s_off < -s_lim) begin
            s_off = -s_lim;
        end
        if (s_no_delay) begin
            s_off = '0;
        end
        s_mag_w = (s_off < 0) ? -s_off : s_off;
        s_mag   = s_mag_w[MAG_BITS-1:0];
    end

    // ---------------- gain stage ----------------
    safd_gain #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_gain_l (
        .i_clk    (i_clk),
        .i_en     (s_accept),
        .i_sample (i_left_sample),
        .i_negate (s_invert),
        .i_gain   (s_gain_l),
        .o_scaled (s_scaled_l)
    );

    safd_gain #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_gain_r (
        .i_clk    (i_clk),
        .i_en     (s_accept),
        .i_sample (i_right_sample),
        .i_negate (1'b0),
        .i_gain   (s_gain_r),
        .o_scaled (s_scaled_r)
    );

    // ---------------- ring ----------------
    always_comb begin
        s_sum_a = {1'b0, r_wp} + {{(AW + 1 - NEAR_BITS){1'b0}}, r_near};
        s_sum_b = s_sum_a + (AW + 1)'(1);
        if (s_sum_a >= DEPTH_W) begin
            s_sum_a = s_sum_a - DEPTH_W;
        end
        if (s_sum_b >= DEPTH_W) begin
            s_sum_b = s_sum_b - DEPTH_W;
        end
        s_rd_addr_a = s_sum_a[AW-1:0];
        s_rd_addr_b = s_sum_b[AW-1:0];

        if (r_state == ST_CLEAR) begin
            s_we      = 1'b1;
            s_wr_addr = r_clr_addr;
            s_wr_data = '0;
        end else begin
            s_we      = (r_state == ST_ACCESS) && (r_del_l || r_del_r);
            s_wr_addr = r_wp;
            s_wr_data = r_del_l ? s_scaled_l : s_scaled_r;
        end
    end

    safd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_wr_en     (s_we),
        .i_wr_addr   (s_wr_addr),
        .i_wr_data   (s_wr_data),
        .i_rd_addr_a (s_rd_addr_a),
        .i_rd_addr_b (s_rd_addr_b),
        .o_rd_data_a (s_rd_data_a),
        .o_rd_data_b (s_rd_data_b)
    );

    // ---------------- interpolation and mix ----------------
    always_comb begin
        s_tap_in = r_del_l ? r_l : r_r;
        // zero whole delay reads the word written in the same cycle: forward it
        s_tap_a  = (r_near == '0) ? s_tap_in : $signed(s_rd_data_a);
        s_tap_b  = $signed(s_rd_data_b);
        // a*256 + (b - a)*frac
        s_diff   = {s_tap_b[SAMPLE_BITS-1], s_tap_b} - {s_tap_a[SAMPLE_BITS-1], s_tap_a};
        s_slope  = s_diff * $signed({1'b0, r_frac});
        s_base   = {{(IW - SAMPLE_BITS - FRAC_BITS){s_tap_a[SAMPLE_BITS-1]}},
                    s_tap_a, {FRAC_BITS{1'b0}}};
        n_interp = s_base + {s_slope[SAMPLE_BITS+FRAC_BITS+1], s_slope};

        s_interp_biased = r_interp + INTERP_BIAS;
        s_tap   = sat_sample(s_interp_biased[IW-1:FRAC_BITS]);
        s_fin_l = r_del_l ? s_tap : r_l;
        s_fin_r = r_del_r ? s_tap : r_r;
        s_mix   = {s_fin_l[SAMPLE_BITS-1], s_fin_l} + {s_fin_r[SAMPLE_BITS-1], s_fin_r};
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: n_state = ST_READ;
            ST_READ:   n_state = ST_FINISH;
            ST_FINISH: begin
                if (s_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_wp        <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // write position steps down once per frame
            if (r_state == ST_ACCESS) begin
                r_wp <= (r_wp == '0) ? LAST_ADDR : r_wp - AW'(1);
            end
            if (s_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_near  <= s_mag[MAG_BITS-1:FRAC_BITS];
            r_frac  <= s_mag[FRAC_BITS-1:0];
            r_del_l <= (s_off > 0);
            r_del_r <= (s_off < 0);
        end
        if (r_state == ST_ACCESS) begin
            r_l <= s_scaled_l;
            r_r <= s_scaled_r;
        end
        if (r_state == ST_READ) begin
            r_interp <= n_interp;
        end
        if (s_load_out) begin
            r_out_data <= sat_sample({{2{s_mix[SAMPLE_BITS]}}, s_mix});
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mono_sample = r_out_data;

    // ---------------- checks ----------------
    a_ring_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> (r_state == ST_CLEAR || r_state == ST_ACCESS))
        else $error("ring written outside clear or access");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS) |=>
            (r_wp == (($past(r_wp) == '0) ? LAST_ADDR : $past(r_wp) - AW'(1))))
        else $error("write position did not step down by one");

    a_far_tap_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS && s_we) |-> (s_rd_addr_b != s_wr_addr))
        else $error("far tap collides with write address");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_FINISH))
        else $error("output word appeared outside mix step");

endmodule : stereo_align_fractional_delay_mono

`default_nettype wire

// ===== bench/safd_checker.sv =====
// Checker: predicts each mono word from the accepted frames and compares it on arrival.
`default_nettype none

module safd_checker
    import safd_pkg::*;
#(
    parameter int RING_DEPTH  = 2048,
    parameter int SAMPLE_BITS = 24
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      i_in_ready,
    input  wire [SAMPLE_BITS-1:0]    i_left_sample,
    input  wire [SAMPLE_BITS-1:0]    i_right_sample,
    input  wire                      i_out_valid,
    input  wire                      i_out_ready,
    input  wire [SAMPLE_BITS-1:0]    i_mono_sample,
    input  wire                      i_cfg_valid,
    input  wire                      i_cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    logic signed [SAMPLE_BITS-1:0]  ring_mem [RING_DEPTH];
    int                             wr_ptr;
    logic signed [BALANCE_BITS-1:0] balance_reg;
    logic signed [OFFSET_BITS-1:0]  offset_reg;
    logic [MODE_BITS-1:0]           mode_reg;
    logic [SAMPLE_BITS-1:0]         mono_expected [$];
    int                             mismatches;
    int                             word_index;

    task automatic report_mismatch(input string msg);
        $display("mismatch at word %0d: %s", word_index, msg);
        mismatches++;
    endtask

    function automatic longint clip_sample(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return v;
    endfunction

    // divide by 2^s, ties go up
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // write the scaled sample at the pointer, then interpolate two taps behind it
    function automatic longint ring_tap(input longint x, input int mag);
        int     near_idx;
        int     frac;
        longint a;
        longint b;
        near_idx = mag >> FRAC_BITS;
        frac     = mag & ((1 << FRAC_BITS) - 1);
        ring_mem[wr_ptr] = x[SAMPLE_BITS-1:0];
        a = ring_mem[(wr_ptr + near_idx) % RING_DEPTH];
        b = ring_mem[(wr_ptr + near_idx + 1) % RING_DEPTH];
        return clip_sample(round_shift(a * ((1 << FRAC_BITS) - frac) + b * frac, FRAC_BITS));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] mix_frame(
        input logic signed [SAMPLE_BITS-1:0] left_in,
        input logic signed [SAMPLE_BITS-1:0] right_in
    );
        longint l;
        longint r;
        longint bal;
        longint gl;
        longint gr;
        longint lim;
        longint off;
        longint sum;
        l   = left_in;
        r   = right_in;
        bal = balance_reg;
        if (bal > HALF_GAIN) bal = HALF_GAIN;
        if (bal < -HALF_GAIN) bal = -HALF_GAIN;
        gl = HALF_GAIN - bal;
        gr = HALF_GAIN + bal;

        lim = (mode_reg == MODE_LONG || mode_reg == MODE_INVERT_LONG) ? LONG_LIMIT : SHORT_LIMIT;
        off = offset_reg;
        if (off > lim) off = lim;
        if (off < -lim) off = -lim;
        if (mode_reg >= MODE_BYPASS) off = 0;
        if (mode_reg > MODE_BYPASS) begin
            gl = HALF_GAIN;
            gr = HALF_GAIN;
        end

        if (mode_reg == MODE_INVERT_SHORT || mode_reg == MODE_INVERT_LONG) l = -l;
        l = clip_sample(round_shift(l * gl, GAIN_SHIFT));
        r = clip_sample(round_shift(r * gr, GAIN_SHIFT));

        if (off > 0)
            l = ring_tap(l, int'(off));
        else if (off < 0)
            r = ring_tap(r, int'(-off));

        wr_ptr = (wr_ptr + RING_DEPTH - 1) % RING_DEPTH;
        sum = clip_sample(l + r);
        return sum[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [SAMPLE_BITS-1:0] want;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++) ring_mem[k] = '0;
            wr_ptr      = 0;
            balance_reg = '0;
            offset_reg  = '0;
            mode_reg    = '0;
            mono_expected.delete();
        end else begin
            if (i_out_valid === 1'b1 && i_out_ready) begin
                if (mono_expected.size() == 0) begin
                    report_mismatch($sformatf("word %h with no frame waiting", i_mono_sample));
                end else begin
                    want = mono_expected.pop_front();
                    if (i_mono_sample !== want)
                        report_mismatch($sformatf("mono_sample %h, want %h",
                                                  i_mono_sample, want));
                end
                word_index++;
            end
            if (i_cfg_valid && i_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    CFG_BALANCE:      balance_reg = i_cfg_data[BALANCE_BITS-1:0];
                    CFG_DELAY_OFFSET: offset_reg  = i_cfg_data[OFFSET_BITS-1:0];
                    CFG_MODE:         mode_reg    = i_cfg_data[MODE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready === 1'b1)
                mono_expected.push_back(mix_frame(i_left_sample, i_right_sample));
        end
        o_pending    = mono_expected.size();
        o_fail_count = mismatches;
    end

endmodule : safd_checker

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench top: frame and config stimulus, output back-pressure, and the verdict.
`default_nettype none

module tb;
    import safd_pkg::*;

    localparam int RING_DEPTH  = 2048;
    localparam int SAMPLE_BITS = 24;

    localparam logic [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // mode codes the package leaves unnamed
    localparam logic [MODE_BITS-1:0] MODE_PLAIN    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
    // index with no register behind it; writes must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam int     RANDOM_PHASES   = 12;
    localparam int     PHASE_WORDS     = 40;
    localparam int     HOLD_OFF_PHASE  = 3;
    localparam int     HOLD_OFF_CYCLES = 80;
    localparam int     TAIL_CYCLES     = 20;
    // bound on the slowest legal run (ring sweep plus worst gaps and stalls)
    localparam longint RUN_LIMIT       = 64'd8_000_000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [SAMPLE_BITS-1:0]    i_left_sample;
    logic [SAMPLE_BITS-1:0]    i_right_sample;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [SAMPLE_BITS-1:0]    o_mono_sample;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    int chk_fail_count;
    int chk_pending;

    // idle knobs, changed per phase
    int in_gap_pct;     // chance of a short gap before a frame
    int out_busy_pct;   // chance the receiver is not ready in a cycle
    bit hold_off_req;   // asks the receiver for one long stall
    bit hold_off_done;  // set by the receiver once that stall is over

    stereo_align_fractional_delay_mono #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mono_sample  (o_mono_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    safd_checker #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_mono_sample  (o_mono_sample),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (chk_fail_count),
        .o_pending      (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(RUN_LIMIT);
        $display("[stereo_align_fractional_delay_mono] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, occasional long holds, and the one long
    // hold-off on request, counted here in cycles while frames keep coming.
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else if (out_busy_pct == 0) begin
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= out_busy_pct);
            end
        end
    end

    // Gap before the next frame: mostly none or short, now and then long.
    function automatic int frame_gap();
        int roll;
        if (in_gap_pct == 0) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 3) return $urandom_range(10, 40);
        if (roll < in_gap_pct) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return FULL_POS;
            1:       return FULL_NEG;
            2:       return SAMPLE_BITS'($urandom_range(0, 255) - 128);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Offer one frame word. Valid is dropped only when a gap is taken, so
    // back-to-back words keep it high without a lower/raise in one step.
    task automatic send_frame(input logic [SAMPLE_BITS-1:0] left,
                              input logic [SAMPLE_BITS-1:0] right);
        int gap;
        gap = frame_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_left_sample  <= left;
        i_right_sample <= right;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write all three registers; unused upper data bits carry noise, and
    // now and then a write to the unused index is slipped in.
    task automatic set_regs(input int bal, input int off, input logic [MODE_BITS-1:0] m);
        logic [CFG_DATA_BITS-1:0] data;
        data = CFG_DATA_BITS'($urandom());
        data[BALANCE_BITS-1:0] = bal[BALANCE_BITS-1:0];
        write_reg(CFG_BALANCE, data);
        data = CFG_DATA_BITS'(off);
        write_reg(CFG_DELAY_OFFSET, data);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom()));
        data = CFG_DATA_BITS'($urandom());
        data[MODE_BITS-1:0] = m;
        write_reg(CFG_MODE, data);
    endtask

    // Random setting, biased toward the extremes and the useful ranges.
    task automatic random_setting();
        logic [MODE_BITS-1:0] m;
        int lim;
        int bal;
        int off;
        int roll;
        if ($urandom_range(0, 99) < 85)
            m = MODE_BITS'($urandom_range(0, 4));
        else
            m = MODE_BITS'($urandom_range(5, 7));
        lim = (m == MODE_LONG || m == MODE_INVERT_LONG) ? LONG_LIMIT : SHORT_LIMIT;

        roll = $urandom_range(0, 99);
        if (roll < 10)      bal = -HALF_GAIN;
        else if (roll < 20) bal = HALF_GAIN;
        else if (roll < 30) bal = 0;
        else if (roll < 40) bal = $urandom();   // full register range, gets clamped
        else                bal = $urandom_range(0, 2 * HALF_GAIN) - HALF_GAIN;

        roll = $urandom_range(0, 99);
        if (roll < 10)      off = $urandom();   // full register range, gets clamped
        else if (roll < 20) off = ($urandom_range(0, 1) != 0) ? lim : -lim;
        else if (roll < 28) off = 0;
        else if (roll < 40) off = $urandom_range(0, 1023) - 512;
        else                off = $urandom_range(0, 2 * lim) - lim;

        set_regs(bal, off, m);
    endtask

    // ------------------------------------------------------------------
    // Directed words: full-scale inputs, zero offset, fractional delay on
    // either side, a side change that reads the other channel's samples and
    // overflows the mono sum, inverted full-scale negative, clamped balance
    // and offset, a spare mode and bypass.
    // ------------------------------------------------------------------
    task automatic run_directed();
        // reset values: no delay, half gains
        send_frame(FULL_POS, FULL_POS);
        send_frame(FULL_NEG, FULL_NEG);
        send_frame(FULL_NEG, FULL_POS);
        send_frame('0, '0);
        drain_outputs();

        // left delayed 5.5 samples, left at full gain
        set_regs(-HALF_GAIN, 5 * 256 + 128, MODE_PLAIN);
        repeat (6) send_frame(FULL_POS, pick_sample());
        drain_outputs();

        // right now delayed: its taps hold full-scale left, so the sum clips
        set_regs(0, -(5 * 256 + 64), MODE_PLAIN);
        repeat (5) send_frame(FULL_POS, FULL_POS);
        drain_outputs();

        // most negative balance and offset, inverted long mode
        set_regs(-(2 * 2 * HALF_GAIN) / 2, -(1 << (OFFSET_BITS - 1)), MODE_INVERT_LONG);
        repeat (3) send_frame(FULL_NEG, FULL_NEG);
        drain_outputs();

        // most positive register values, spare mode forces half gains
        set_regs((1 << (BALANCE_BITS - 1)) - 1, (1 << (OFFSET_BITS - 1)) - 1, MODE_SPARE_HI);
        send_frame(FULL_POS, FULL_NEG);
        send_frame(FULL_POS, FULL_POS);
        send_frame(FULL_NEG, FULL_NEG);
        drain_outputs();

        set_regs(HALF_GAIN, 1, MODE_BYPASS);
        repeat (2) send_frame(pick_sample(), FULL_POS);
        drain_outputs();

        // exactly the long limit
        set_regs(0, LONG_LIMIT, MODE_LONG);
        repeat (2) send_frame(FULL_POS, pick_sample());
        drain_outputs();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_left_sample  = '0;
        i_right_sample = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        in_gap_pct     = 20;
        out_busy_pct   = 25;
        hold_off_req   = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first frames wait out the ring sweep on o_in_ready
        run_directed();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_setting();
            case ($urandom_range(0, 2))
                0:       in_gap_pct = 0;
                1:       in_gap_pct = 20;
                default: in_gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0:       out_busy_pct = 0;
                1:       out_busy_pct = 25;
                default: out_busy_pct = 50;
            endcase
            if (phase == 1) begin
                // one stretch with no idling on either side
                in_gap_pct   = 0;
                out_busy_pct = 0;
            end
            if (phase == HOLD_OFF_PHASE) begin
                // sender keeps offering while the receiver holds off
                in_gap_pct   = 0;
                hold_off_req = 1'b1;
            end
            repeat (PHASE_WORDS) send_frame(pick_sample(), pick_sample());
            // sender pauses until every word is out before reconfiguring
            drain_outputs();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (chk_fail_count == 0)
            $display("[stereo_align_fractional_delay_mono] OK");
        else
            $display("[stereo_align_fractional_delay_mono] ERROR");
        $finish;
    end

endmodule : tb

`default_nettype wire

// ===== files.f =====
hdl/safd_pkg.sv
hdl/safd_ram.sv
hdl/safd_gain.sv
hdl/stereo_align_fractional_delay_mono.sv
bench/safd_checker.sv
bench/tb.sv
